// ===== src/pwc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Pulse width capture package
// Shared constants, register indexes and control structures of the
// multichannel pulse width capture block.
// ---------------------------------------------------------------------------
package pwc_pkg;

   localparam int PIN_COUNT      = 6;
   localparam int FINE_BITS      = 16;
   localparam int COARSE_BITS    = 32;
   localparam int PERIOD_BITS    = 17;
   localparam int WDOG_BITS      = 24;
   localparam int PROD_BITS      = COARSE_BITS + PERIOD_BITS;
   localparam int SUM_BITS       = PROD_BITS + 1;
   localparam int CHANNEL_BITS   = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FINE_PERIOD     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WATCHDOG_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_ENABLE  = 2'd2;

   // register reset values
   localparam logic [PERIOD_BITS-1:0] FINE_PERIOD_RESET = 17'd50000;
   localparam logic [WDOG_BITS-1:0]   WDOG_PERIOD_RESET = 24'd200000;
   localparam logic [PIN_COUNT-1:0]   ENABLE_RESET      = 6'h3F;

   // largest usable fine period
   localparam logic [PERIOD_BITS-1:0] FINE_PERIOD_MAX   = 17'd65536;

   // result kinds
   localparam logic KIND_PULSE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // watchdog outcome travelling with one request
   typedef struct packed {
      logic due;
      logic good;
      logic lamp;
   } status_type;

   // per-lane control from the front end
   typedef struct packed {
      logic load1;
      logic load2;
      logic rise;
      logic fall;
   } lane_ctl_type;

endpackage : pwc_pkg
`default_nettype wire

// ===== src/pwc_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Pulse width capture channels
// Request channel carrying the sampled pins of one tick, and result channel
// carrying one measured pulse or one watchdog status.
// ---------------------------------------------------------------------------
interface pwc_req_if import pwc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PIN_COUNT-1:0] pin_levels;

   modport source (output valid, output pin_levels, input ready);
   modport sink   (input valid, input pin_levels, output ready);
endinterface : pwc_req_if

interface pwc_rsp_if import pwc_pkg::*; #(
   parameter int WIDTH_BITS = 24
) ();
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [CHANNEL_BITS-1:0] channel;
   logic [WIDTH_BITS-1:0]   width;
   logic                    saturated;
   logic                    signal_good;
   logic                    led_level;
   logic                    last;

   modport source (output valid, output kind, output channel, output width,
                   output saturated, output signal_good, output led_level,
                   output last, input ready);
   modport sink   (input valid, input kind, input channel, input width,
                   input saturated, input signal_good, input led_level,
                   input last, output ready);
endinterface : pwc_rsp_if
`default_nettype wire

// ===== src/pwc_lane.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Pulse width capture lane
// Holds one pin's start time, forms the coarse and fine differences on a
// falling edge, multiplies by the period and saturates the width.
// ---------------------------------------------------------------------------
module pwc_lane import pwc_pkg::*; #(
   parameter int WIDTH_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lane_ctl_type           ctl,
   input  logic [FINE_BITS-1:0]   fine_count,
   input  logic [COARSE_BITS-1:0] coarse_count,
   input  logic [PERIOD_BITS-1:0] period,
   output logic                   hit,
   output logic [WIDTH_BITS-1:0]  width,
   output logic                   sat
);

   logic [COARSE_BITS-1:0] start_coarse_ff;
   logic [FINE_BITS-1:0]   start_fine_ff;
   logic                   s1_hit_ff;
   logic [COARSE_BITS-1:0] s1_cdiff_ff;
   logic [PERIOD_BITS-1:0] s1_fdiff_ff;
   logic                   s2_hit_ff;
   logic [PROD_BITS-1:0]   s2_prod_ff;
   logic [PERIOD_BITS-1:0] s2_fdiff_ff;

   logic [COARSE_BITS-1:0] s1_cdiff_in;
   logic [PERIOD_BITS-1:0] s1_fdiff_in;
   logic [PROD_BITS-1:0]   s2_prod_in;
   logic [SUM_BITS-1:0]    sum;
   logic                   negative;
   logic                   over;

   assign s1_cdiff_in = coarse_count - start_coarse_ff;
   assign s1_fdiff_in = {1'b0, fine_count} - {1'b0, start_fine_ff};
   assign s2_prod_in  = {{PERIOD_BITS{1'b0}}, s1_cdiff_ff}
                        * {{COARSE_BITS{1'b0}}, period};

   // fine difference is signed: widen with its sign bit
   assign sum      = {1'b0, s2_prod_ff}
                     + {{(SUM_BITS-PERIOD_BITS){s2_fdiff_ff[PERIOD_BITS-1]}}, s2_fdiff_ff};
   assign negative = sum[SUM_BITS-1];
   assign over     = |sum[SUM_BITS-2:WIDTH_BITS];

   always_comb begin
      hit = s2_hit_ff;
      sat = negative | over;
      if (negative) begin
         width = '0;
      end else if (over) begin
         width = '1;
      end else begin
         width = sum[WIDTH_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_coarse_ff <= '0;
         start_fine_ff   <= '0;
         s1_hit_ff       <= 1'b0;
         s2_hit_ff       <= 1'b0;
      end else begin
         if (ctl.rise) begin
            start_coarse_ff <= coarse_count;
            start_fine_ff   <= fine_count;
         end
         if (ctl.load1) begin
            s1_hit_ff <= ctl.fall;
         end
         if (ctl.load2) begin
            s2_hit_ff <= s1_hit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load1 && ctl.fall) begin
         s1_cdiff_ff <= s1_cdiff_in;
         s1_fdiff_ff <= s1_fdiff_in;
      end
      if (ctl.load2) begin
         s2_prod_ff  <= s2_prod_in;
         s2_fdiff_ff <= s1_fdiff_ff;
      end
   end

endmodule : pwc_lane
`default_nettype wire

// ===== src/pwc_merge.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Pulse width capture merge stage
// Collects the lane results and the watchdog status of one request and sends
// them one per cycle while rsp_bus is ready, lowest pin first, status last.
// ---------------------------------------------------------------------------
module pwc_merge import pwc_pkg::*; #(
   parameter int CHANNELS   = 6,
   parameter int WIDTH_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [CHANNELS-1:0]   hits,
   input  logic [WIDTH_BITS-1:0] widths [CHANNELS],
   input  logic [CHANNELS-1:0]   sats,
   input  status_type            status,
   output logic                  busy,
   pwc_rsp_if.source             rsp_bus
);

   localparam int IDX_BITS  = $clog2(CHANNELS + 1);
   localparam int LANE_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [CHANNELS:0]     pend_ff;
   logic [CHANNELS:0]     pend_in;
   logic [WIDTH_BITS-1:0] width_ff [CHANNELS];
   logic [CHANNELS-1:0]   sat_ff;
   logic                  good_ff;
   logic                  lamp_ff;

   logic [IDX_BITS-1:0]   sel;
   logic [LANE_BITS-1:0]  lane_sel;
   logic [CHANNELS:0]     rest;
   logic                  is_status;
   logic                  load;
   logic                  fire;

   always_comb begin
      sel = '0;
      for (int i = CHANNELS; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = IDX_BITS'(i);
         end
      end
   end

   assign busy      = |pend_ff;
   assign load      = in_valid && !busy;
   assign fire      = rsp_bus.valid && rsp_bus.ready;
   assign rest      = pend_ff & ~((CHANNELS + 1)'(1) << sel);
   assign is_status = (sel == IDX_BITS'(CHANNELS));
   assign lane_sel  = is_status ? '0 : sel[LANE_BITS-1:0];

   always_comb begin
      pend_in = pend_ff;
      if (load) begin
         pend_in = {status.due, hits};
      end else if (fire) begin
         pend_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         width_ff <= widths;
         sat_ff   <= sats;
         good_ff  <= status.good;
         lamp_ff  <= status.lamp;
      end
   end

   always_comb begin
      rsp_bus.valid       = busy;
      rsp_bus.kind        = is_status ? KIND_STATUS : KIND_PULSE;
      rsp_bus.channel     = is_status ? '0
                            : CHANNEL_BITS'(CHANNELS - 1 - int'(lane_sel));
      rsp_bus.width       = is_status ? '0 : width_ff[lane_sel];
      rsp_bus.saturated   = is_status ? 1'b0 : sat_ff[lane_sel];
      rsp_bus.signal_good = is_status ? good_ff : 1'b0;
      rsp_bus.led_level   = is_status ? lamp_ff : 1'b0;
      rsp_bus.last        = (rest == '0);
   end

endmodule : pwc_merge
`default_nettype wire

// ===== src/multichannel_pulse_width_capture.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Multichannel pulse width capture
// Measures the high time of up to six pulse pins against a fine/coarse
// time base and reports a periodic signal-presence watchdog status.
//
// Usage:
//  - req_bus carries one request per microsecond tick: the sampled level of
//    the pins (bit i is pin i). Pin i reports on channel CHANNELS-1-i.
//  - rsp_bus returns zero or more results per request: one per completed
//    pulse in pin order 0 upward, then the watchdog status when a check is
//    due. The final result of a request has last set; a request that
//    completes nothing and hits no check returns nothing.
//  - csr_we/csr_index/csr_wdata write fine_period (0), watchdog_period (1)
//    and channel_enable (2); write only while the block is idle.
//  - A request's first result is registered through the lane difference,
//    the multiply and the saturate into the merge stage, in that order.
//  - A request enters every cycle while the pipeline has room; the merge
//    stage sends one result per cycle while rsp_bus is ready, and takes the
//    next request only after the last result of the current one is sent.
//  - A stalled rsp_bus holds the merge stage; up to two more requests,
//    one per lane stage, enter the lane pipeline before req_bus.ready drops.
//  - Reset (synchronous) clears counters, start times and the watchdog and
//    loads the default periods and enables.
// ---------------------------------------------------------------------------
module multichannel_pulse_width_capture import pwc_pkg::*; #(
   parameter int CHANNELS   = 6,
   parameter int WIDTH_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   pwc_req_if.sink                   req_bus,
   pwc_rsp_if.source                 rsp_bus,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // configuration registers
   logic [PERIOD_BITS-1:0] fine_period_ff;
   logic [WDOG_BITS-1:0]   wdog_period_ff;
   logic [PIN_COUNT-1:0]   enable_ff;

   // time base and watchdog state
   logic [FINE_BITS-1:0]   fine_ff;
   logic [FINE_BITS-1:0]   fine_in;
   logic [COARSE_BITS-1:0] coarse_ff;
   logic [COARSE_BITS-1:0] coarse_in;
   logic [CHANNELS-1:0]    prev_ff;
   logic                   seen_ff;
   logic                   seen_in;
   logic [WDOG_BITS-1:0]   check_ff;
   logic [WDOG_BITS-1:0]   check_in;
   logic                   lamp_ff;

   // pipeline occupancy and per-request side data
   logic                   v1_ff;
   logic                   v2_ff;
   status_type             s1_status_ff;
   status_type             s2_status_ff;
   status_type             status_in;
   logic [PERIOD_BITS-1:0] s1_per_ff;

   logic [CHANNELS-1:0]    levels;
   logic [CHANNELS-1:0]    en_mask;
   logic [CHANNELS-1:0]    rise;
   logic [CHANNELS-1:0]    fall;
   logic [PERIOD_BITS-1:0] per_eff;
   logic [PERIOD_BITS-1:0] fine_next;
   logic [WDOG_BITS-1:0]   wdog_eff;
   logic [WDOG_BITS-1:0]   check_next;
   logic                   due;
   logic                   seen_now;
   logic                   accept;
   logic                   s1_ready;
   logic                   s2_ready;
   logic                   merge_busy;

   logic [CHANNELS-1:0]    lane_hit;
   logic [CHANNELS-1:0]    lane_sat;
   logic [WIDTH_BITS-1:0]  lane_width [CHANNELS];

   // ---- configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fine_period_ff <= FINE_PERIOD_RESET;
         wdog_period_ff <= WDOG_PERIOD_RESET;
         enable_ff      <= ENABLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FINE_PERIOD: begin
               fine_period_ff <= csr_wdata[PERIOD_BITS-1:0];
            end
            CSR_WATCHDOG_PERIOD: begin
               wdog_period_ff <= csr_wdata[WDOG_BITS-1:0];
            end
            CSR_CHANNEL_ENABLE: begin
               enable_ff <= csr_wdata[PIN_COUNT-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---- pins beyond the physical six read low and never capture
   for (genvar i = 0; i < CHANNELS; i++) begin : g_pin
      if (i < PIN_COUNT) begin : g_live
         assign levels[i]  = req_bus.pin_levels[i];
         assign en_mask[i] = enable_ff[i];
      end else begin : g_dead
         assign levels[i]  = 1'b0;
         assign en_mask[i] = 1'b0;
      end
   end

   // ---- handshake: two lane stages, then the merge stage
   assign s2_ready      = !v2_ff || !merge_busy;
   assign s1_ready      = !v1_ff || s2_ready;
   assign req_bus.ready = s1_ready;
   assign accept        = req_bus.valid && s1_ready;

   // ---- edges judged against this tick's counts
   assign rise = levels & ~prev_ff & en_mask;
   assign fall = ~levels & prev_ff & en_mask;

   // ---- time base: clamp the period to 1..65536, wrap fine into coarse
   always_comb begin
      if (fine_period_ff == '0) begin
         per_eff = PERIOD_BITS'(1);
      end else if (fine_period_ff > FINE_PERIOD_MAX) begin
         per_eff = FINE_PERIOD_MAX;
      end else begin
         per_eff = fine_period_ff;
      end
      fine_next = {1'b0, fine_ff} + PERIOD_BITS'(1);
      if (fine_next >= per_eff) begin
         fine_in   = '0;
         coarse_in = coarse_ff + COARSE_BITS'(1);
      end else begin
         fine_in   = fine_next[FINE_BITS-1:0];
         coarse_in = coarse_ff;
      end
   end

   // ---- watchdog: pulses of this tick count toward a check due now
   always_comb begin
      wdog_eff   = (wdog_period_ff == '0) ? WDOG_BITS'(1) : wdog_period_ff;
      check_next = check_ff + WDOG_BITS'(1);
      due        = (check_next >= wdog_eff) || (check_next == '0);
      seen_now   = seen_ff | (|fall);
      status_in.due  = due;
      status_in.good = seen_now;
      status_in.lamp = seen_now ? 1'b1 : ~lamp_ff;
      if (due) begin
         check_in = '0;
         seen_in  = 1'b0;
      end else begin
         check_in = check_next;
         seen_in  = seen_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fine_ff   <= '0;
         coarse_ff <= '0;
         prev_ff   <= '0;
         seen_ff   <= 1'b0;
         check_ff  <= '0;
         lamp_ff   <= 1'b0;
      end else if (accept) begin
         fine_ff   <= fine_in;
         coarse_ff <= coarse_in;
         prev_ff   <= levels;
         seen_ff   <= seen_in;
         check_ff  <= check_in;
         if (due) begin
            lamp_ff <= status_in.lamp;
         end
      end
   end

   // ---- pipeline occupancy; a bubble carries no status
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         s1_status_ff <= '0;
         s2_status_ff <= '0;
      end else begin
         if (s1_ready) begin
            v1_ff        <= accept;
            s1_status_ff <= accept ? status_in : '0;
         end
         if (s2_ready) begin
            v2_ff        <= v1_ff;
            s2_status_ff <= s1_status_ff;
         end
      end
   end

   // hold the period with the request for the multiply stage
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_per_ff <= per_eff;
      end
   end

   // ---- one lane per pin
   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      lane_ctl_type ctl;

      assign ctl.load1 = s1_ready;
      assign ctl.load2 = s2_ready;
      assign ctl.rise  = accept && rise[i] && !fall[i];
      assign ctl.fall  = accept && fall[i];

      pwc_lane #(
         .WIDTH_BITS (WIDTH_BITS)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .fine_count   (fine_ff),
         .coarse_count (coarse_ff),
         .period       (s1_per_ff),
         .hit          (lane_hit[i]),
         .width        (lane_width[i]),
         .sat          (lane_sat[i])
      );
   end

   // ---- serialize the lane results and the status
   pwc_merge #(
      .CHANNELS   (CHANNELS),
      .WIDTH_BITS (WIDTH_BITS)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v2_ff),
      .hits     (lane_hit),
      .widths   (lane_width),
      .sats     (lane_sat),
      .status   (s2_status_ff),
      .busy     (merge_busy),
      .rsp_bus  (rsp_bus)
   );

   // ---- checks
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_STATUS) |-> rsp_bus.last)
      else $error("status result not marked last");

   a_pulse_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_PULSE)
      |-> (!rsp_bus.signal_good && !rsp_bus.led_level))
      else $error("pulse result carries status bits");

   a_good_lamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_STATUS && rsp_bus.signal_good)
      |-> rsp_bus.led_level)
      else $error("good signal without lamp on");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && merge_busy) |=> v2_ff)
      else $error("request dropped while merge stage busy");

endmodule : multichannel_pulse_width_capture
`default_nettype wire
